// File: rtl/slot_window_broadcast_dedup_assert.svh
// assertion macros used by swbd_seq
`ifndef SLOT_WINDOW_BROADCAST_DEDUP_ASSERT_SVH
`define SLOT_WINDOW_BROADCAST_DEDUP_ASSERT_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define SWBD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in this cycle, consequent in the next one
`define SWBD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/swbd_pkg.sv
`default_nettype none
package swbd_pkg;

    localparam int SLOT_W    = 32;
    localparam int ID_WORD_W = 64;
    localparam int ID_W      = 4 * ID_WORD_W;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 4;
    localparam int S_DATA_W  = 296;  // slot, four id words, record flag, padded
    localparam int M_DATA_W  = 8;

    localparam logic OP_PRECHECK = 1'b0;
    localparam logic OP_FINALIZE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DESYNC = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SPW    = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FINAL = 2'd1,
        ST_AHEAD = 2'd2,
        ST_DUP   = 2'd3
    } swbd_status_t;

    // table write strobes from the sequencer
    typedef struct packed {
        logic tag_we;
        logic valid_set;
        logic valid_clr;
        logic id_we;
    } swbd_mem_ctl_t;

endpackage
`default_nettype wire

// File: rtl/swbd_mem.sv
`default_nettype none
module swbd_mem
    import swbd_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire swbd_mem_ctl_t         ctl,
    input  wire logic [IDX_W-1:0]      waddr,
    input  wire logic [SLOT_W-1:0]     wtag,
    input  wire logic [IDX_W-1:0]      tag_raddr,
    input  wire logic [IDX_W+1:0]      id_waddr,
    input  wire logic [ID_WORD_W-1:0]  id_wdata,
    input  wire logic [IDX_W+1:0]      id_raddr,
    output logic      [SLOT_W-1:0]     tag_rdata,
    output logic                       valid_rdata,
    output logic      [ID_WORD_W-1:0]  id_rdata
);

    logic [SLOT_W-1:0]    tag_mem [DEPTH];
    logic [ID_WORD_W-1:0] id_mem  [4*DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [DEPTH-1:0]     valid_next;

    always_comb begin
        valid_next = valid_reg;
        if (ctl.valid_set) begin
            valid_next[waddr] = 1'b1;
        end
        if (ctl.valid_clr) begin
            valid_next[waddr] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.tag_we) begin
            tag_mem[waddr] <= wtag;
        end
        tag_rdata   <= tag_mem[tag_raddr];
        valid_rdata <= valid_reg[tag_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.id_we) begin
            id_mem[id_waddr] <= id_wdata;
        end
        id_rdata <= id_mem[id_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/swbd_seq.sv
`default_nettype none
module swbd_seq
    import swbd_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  in_op,
    input  wire logic [SLOT_W-1:0]     in_slot,
    input  wire logic [ID_W-1:0]       in_id,
    input  wire logic                  in_rec,
    input  wire logic [CFG_W-1:0]      desync,
    input  wire logic [CFG_W-1:0]      spw,
    input  wire logic                  out_free,
    output logic                       res_valid,
    output swbd_status_t               res_status,
    output swbd_mem_ctl_t              ctl,
    output logic      [IDX_W-1:0]      waddr,
    output logic      [SLOT_W-1:0]     wtag,
    output logic      [IDX_W-1:0]      tag_raddr,
    output logic      [IDX_W+1:0]      id_waddr,
    output logic      [ID_WORD_W-1:0]  id_wdata,
    output logic      [IDX_W+1:0]      id_raddr,
    input  wire logic [SLOT_W-1:0]     tag_rdata,
    input  wire logic                  valid_rdata,
    input  wire logic [ID_WORD_W-1:0]  id_rdata
);

    localparam bit IS_POW2 = (DEPTH & (DEPTH - 1)) == 0;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    // rounded-up reciprocal of the table depth, exact quotient for any 32-bit slot
    localparam logic [SLOT_W:0]  RECIP =
        (SLOT_W+1)'(((64'd1 << (SLOT_W + IDX_W)) + 64'(DEPTH - 1)) / 64'(DEPTH));

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_LOW  = 11'b000_0000_0010,
        S_LIM  = 11'b000_0000_0100,
        S_HIGH = 11'b000_0000_1000,
        S_MOD  = 11'b000_0001_0000,
        S_RDT  = 11'b000_0010_0000,
        S_TAG  = 11'b000_0100_0000,
        S_IDC  = 11'b000_1000_0000,
        S_WR   = 11'b001_0000_0000,
        S_SWP  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic                op_reg, op_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic                rec_reg, rec_next;
    logic [SLOT_W-1:0]   base_reg, base_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    quo_reg, quo_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [1:0]          w_reg, w_next;
    logic                mis_reg, mis_next;
    swbd_status_t        status_reg, status_next;
    logic [2*CFG_W-1:0]  prod_reg, prod_next;
    logic [SLOT_W:0]     limit_reg, limit_next;

    // the one compare unit that the slot, tag and id compare steps go through
    logic [ID_WORD_W:0]  cmp_a, cmp_b;
    logic                cmp_lt, cmp_eq;
    logic [2*SLOT_W:0]   recip_prod;
    logic [IDX_W-1:0]    rem_low;
    logic [IDX_W-1:0]    win_cap;
    logic                accept;

    assign cmp_lt = cmp_a < cmp_b;
    assign cmp_eq = cmp_a == cmp_b;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign recip_prod = slot_reg * RECIP;
    // remainder is below the depth, so the low index bits are enough
    assign rem_low    = slot_reg[IDX_W-1:0] - IDX_W'(quo_reg * SLOT_W'(DEPTH));
    assign win_cap    = (prod_reg > 32'(DEPTH - 1)) ? LAST_IDX : prod_reg[IDX_W-1:0];

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        slot_next   = slot_reg;
        id_next     = id_reg;
        rec_next    = rec_reg;
        base_next   = base_reg;
        idx_next    = idx_reg;
        quo_next    = quo_reg;
        k_next      = k_reg;
        w_next      = w_reg;
        mis_next    = mis_reg;
        status_next = status_reg;
        prod_next   = prod_reg;
        limit_next  = limit_reg;
        cmp_a       = '0;
        cmp_b       = '0;
        ctl         = '0;
        waddr       = idx_reg;
        wtag        = slot_reg;
        tag_raddr   = '0;
        id_waddr    = {idx_reg, w_reg};
        id_wdata    = id_reg[w_reg*ID_WORD_W +: ID_WORD_W];
        id_raddr    = {idx_reg, 2'd0};
        res_valid   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next     = in_op;
                    slot_next   = in_slot;
                    id_next     = in_id;
                    rec_next    = in_rec;
                    idx_next    = in_slot[IDX_W-1:0];
                    status_next = ST_OK;
                    k_next      = '0;
                    if (in_op == OP_FINALIZE) begin
                        // base wraps to zero after the last slot
                        base_next  = in_slot + 32'd1;
                        state_next = S_SWP;
                    end else begin
                        state_next = S_LOW;
                    end
                end
            end
            S_LOW: begin
                cmp_a     = 65'(slot_reg);
                cmp_b     = 65'(base_reg);
                prod_next = desync * spw;
                if (cmp_lt) begin
                    status_next = ST_FINAL;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_LIM;
                end
            end
            S_LIM: begin
                limit_next = {1'b0, base_reg} + 33'(win_cap);
                quo_next   = IDX_W'(recip_prod >> (SLOT_W + IDX_W));
                state_next = S_HIGH;
            end
            S_HIGH: begin
                cmp_a = 65'(limit_reg);
                cmp_b = 65'(slot_reg);
                if (cmp_lt) begin
                    status_next = ST_AHEAD;
                    state_next  = S_DONE;
                end else if (IS_POW2) begin
                    state_next = S_RDT;
                end else begin
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                // table index from the registered quotient
                idx_next   = rem_low;
                state_next = S_RDT;
            end
            S_RDT: begin
                tag_raddr  = idx_reg;
                w_next     = 2'd0;
                mis_next   = 1'b0;
                state_next = S_TAG;
            end
            S_TAG: begin
                cmp_a = 65'(tag_rdata);
                cmp_b = 65'(slot_reg);
                if (valid_rdata && cmp_eq) begin
                    state_next = S_IDC;
                end else if (rec_reg) begin
                    // an empty entry or one of another slot is overwritten
                    ctl.tag_we    = 1'b1;
                    ctl.valid_set = 1'b1;
                    state_next    = S_WR;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_IDC: begin
                cmp_a    = 65'(id_rdata);
                cmp_b    = 65'(id_reg[w_reg*ID_WORD_W +: ID_WORD_W]);
                id_raddr = {idx_reg, w_reg + 2'd1};
                mis_next = mis_reg || !cmp_eq;
                w_next   = w_reg + 2'd1;
                if (w_reg == 2'd3) begin
                    status_next = mis_next ? ST_DUP : ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_WR: begin
                ctl.id_we = 1'b1;
                w_next    = w_reg + 2'd1;
                if (w_reg == 2'd3) begin
                    state_next = S_DONE;
                end
            end
            S_SWP: begin
                // tag of entry k arrived this cycle, fetch k+1
                cmp_a     = 65'(tag_rdata);
                cmp_b     = 65'(base_reg);
                waddr     = k_reg;
                tag_raddr = k_reg + 1'b1;
                ctl.valid_clr = valid_rdata && cmp_lt;
                k_next    = k_reg + 1'b1;
                if (k_reg == LAST_IDX) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_status = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            base_reg  <= '0;
        end else begin
            state_reg <= state_next;
            base_reg  <= base_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        slot_reg   <= slot_next;
        id_reg     <= id_next;
        rec_reg    <= rec_next;
        idx_reg    <= idx_next;
        quo_reg    <= quo_next;
        k_reg      <= k_next;
        w_reg      <= w_next;
        mis_reg    <= mis_next;
        status_reg <= status_next;
        prod_reg   <= prod_next;
        limit_reg  <= limit_next;
    end

`include "slot_window_broadcast_dedup_assert.svh"

    `SWBD_ASSERT_IMP(a_sweep_step, aclk, aresetn, (state_reg == S_SWP) && $past(state_reg == S_SWP), k_reg == IDX_W'($past(k_reg) + 1'b1), "sweep index skipped an entry")
    `SWBD_ASSERT_IMP(a_id_write_rec, aclk, aresetn, ctl.id_we, rec_reg && (op_reg == OP_PRECHECK), "id written without a recording precheck")
    `SWBD_ASSERT_NXT(a_final_base, aclk, aresetn, accept && (in_op == OP_FINALIZE), base_reg == $past(in_slot) + 32'd1, "base not moved past the finalized slot")
    `SWBD_ASSERT_IMP(a_ahead_above, aclk, aresetn, res_valid && (res_status == ST_AHEAD), slot_reg > base_reg, "too-far-ahead status for a slot not above base")

endmodule
`default_nettype wire

// File: rtl/slot_window_broadcast_dedup.sv
`default_nettype none
// Broadcast slot window and duplicate filter. Each input beat is either a
// precheck (tuser 0) or a finalize (tuser 1) and yields exactly one status beat.
// A precheck compares the slot with base, forms the window limit and checks the slot
// against it, takes the table index from the slot bits with a power-of-two DEPTH (else
// from a reciprocal multiply), reads the tag and, on a match or when recording,
// compares or writes the 256-bit id one 64-bit word per cycle through the single
// compare unit and the 64-bit-wide id memory. A slot below base or too far ahead is
// answered without a table access. A finalize walks every table entry, one tag read
// per cycle. The block takes one beat at a time; a finished status may wait in the
// output register while the next beat is accepted, and while that register is still
// held by the sink a new status waits too. Configuration is read at each base compare.
// No clearing pass follows reset: the valid bits clear at once.
module slot_window_broadcast_dedup
    import swbd_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // slot[31:0], id_word0..3[287:32], record_if_new[288], zero pad
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // opcode
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // status[1:0], zero pad
    output logic      [M_DATA_W-1:0]   m_tdata
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [CFG_W-1:0]     desync_reg, desync_next;
    logic [CFG_W-1:0]     spw_reg, spw_next;
    logic                 mvalid_reg, mvalid_next;
    swbd_status_t         mstatus_reg, mstatus_next;

    logic                 res_valid;
    swbd_status_t         res_status;
    swbd_mem_ctl_t        ctl;
    logic [IDX_W-1:0]     waddr, tag_raddr;
    logic [SLOT_W-1:0]    wtag, tag_rdata;
    logic [IDX_W+1:0]     id_waddr, id_raddr;
    logic [ID_WORD_W-1:0] id_wdata, id_rdata;
    logic                 valid_rdata;
    logic                 out_free;

    always_comb begin
        desync_next = desync_reg;
        spw_next    = spw_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_DESYNC: desync_next = cfg_wdata;
                REG_SPW:    spw_next    = cfg_wdata;
                default:    ;
            endcase
        end
    end

    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        mvalid_next  = mvalid_reg;
        mstatus_next = mstatus_reg;
        if (res_valid) begin
            mvalid_next  = 1'b1;
            mstatus_next = res_status;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desync_reg <= '0;
            spw_reg    <= CFG_W'(1);
            mvalid_reg <= 1'b0;
        end else begin
            desync_reg <= desync_next;
            spw_reg    <= spw_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mstatus_reg <= mstatus_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(M_DATA_W-2){1'b0}}, mstatus_reg};

    swbd_seq #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_slot     (s_tdata[SLOT_W-1:0]),
        .in_id       (s_tdata[SLOT_W +: ID_W]),
        .in_rec      (s_tdata[SLOT_W+ID_W]),
        .desync      (desync_reg),
        .spw         (spw_reg),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res_status  (res_status),
        .ctl         (ctl),
        .waddr       (waddr),
        .wtag        (wtag),
        .tag_raddr   (tag_raddr),
        .id_waddr    (id_waddr),
        .id_wdata    (id_wdata),
        .id_raddr    (id_raddr),
        .tag_rdata   (tag_rdata),
        .valid_rdata (valid_rdata),
        .id_rdata    (id_rdata)
    );

    swbd_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .waddr       (waddr),
        .wtag        (wtag),
        .tag_raddr   (tag_raddr),
        .id_waddr    (id_waddr),
        .id_wdata    (id_wdata),
        .id_raddr    (id_raddr),
        .tag_rdata   (tag_rdata),
        .valid_rdata (valid_rdata),
        .id_rdata    (id_rdata)
    );

endmodule
`default_nettype wire
